/* hw/rtl/lkvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants shared by the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CFG_W      = 5;
  localparam int IN_DATA_W  = KEY_W + VAL_W;
  localparam int OUT_DATA_W = VAL_W;
  localparam int OUT_USER_W = 2;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANK,
    ST_KEY,
    ST_CMP,
    ST_MISS,
    ST_HITV,
    ST_INS_RD,
    ST_INS_SLOT,
    ST_MV_RD,
    ST_MV_WR,
    ST_DONE
  } state_t;

endpackage

/* hw/rtl/lru_key_value_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each get or put request yields one result item. Keys, values and the
// recency order sit in memories with one registered read port and one
// write port each. One key comparator walks the recency order from the
// most recent entry, through a rank read, a key read and a compare for
// each rank. The entry is then moved to the front one rank at a time, with
// a rank read and a rank write per step. After an item is accepted,
// in_tready stays low until the request is finished; a put that inserts
// first writes the new key and value, and a get miss skips the move.
// The result item is registered as in_tready returns high. The wait grows
// while an earlier result item is still held at the output. The single rank
// read port and the single comparator set the length of the wait.
// No clearing pass runs after reset. The user must write the capacity limit
// only while the block is idle; the block does not enforce this. Zero acts
// as 1 and values above ENTRIES act as ENTRIES.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lkvc_pkg::CFG_W-1:0]        cfg_wr_data,   // capacity_limit
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lkvc_pkg::IN_DATA_W-1:0]    in_tdata,      // lookup_key, write_value
  input  logic                              in_tuser,      // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lkvc_pkg::OUT_DATA_W-1:0]   out_tdata,     // read_value
  output logic [lkvc_pkg::OUT_USER_W-1:0]   out_tuser      // hit, evicted
);

  import lkvc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  logic [KEY_W-1:0] key_mem  [ENTRIES];
  logic [VAL_W-1:0] val_mem  [ENTRIES];
  logic [IW-1:0]    rank_mem [ENTRIES];

  state_t            state_r, state_nxt;
  logic [CW-1:0]     r_cnt_r, r_cnt_nxt;
  logic [CW-1:0]     mv_cnt_r, mv_cnt_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [IW-1:0]     slot_r, slot_nxt;
  logic              is_put_r, is_put_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  wval_r, wval_nxt;
  logic              grow_r, grow_nxt;
  logic              hit_r, hit_nxt;
  logic              ev_r, ev_nxt;
  logic [VAL_W-1:0]  rd_r, rd_nxt;
  logic [CFG_W-1:0]  cap_r;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic [IW-1:0]     rank_rd_addr;
  logic [IW-1:0]     rank_q;
  logic [IW-1:0]     rank_addr_q;
  logic              rank_fill_q;
  logic [IW-1:0]     rank_eff;
  logic              rank_we;
  logic [IW-1:0]     rank_wa;
  logic [IW-1:0]     rank_wd;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic              key_we;
  logic              val_we;
  logic [IW-1:0]     kv_wa;
  logic [LW-1:0]     cap_ext;
  logic [LW-1:0]     lim;
  logic              load_out;

  assign cap_ext = LW'(cap_r);
  assign lim = (cap_ext == '0) ? LW'(1) :
               (cap_ext > LW'(ENTRIES)) ? LW'(ENTRIES) : cap_ext;

  assign rank_eff = rank_fill_q ? rank_addr_q : rank_q;

  // Memories: registered reads, ranks at or above occupancy read as identity
  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    rank_q      <= rank_mem[rank_rd_addr];
    rank_addr_q <= rank_rd_addr;
    rank_fill_q <= (CW'(rank_rd_addr) >= occ_r);
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[kv_wa] <= key_r;
    end
    key_q <= key_mem[rank_eff];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[kv_wa] <= wval_r;
    end
    val_q <= val_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
      grow_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      grow_r      <= grow_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_cnt_r    <= r_cnt_nxt;
    mv_cnt_r   <= mv_cnt_nxt;
    slot_r     <= slot_nxt;
    is_put_r   <= is_put_nxt;
    key_r      <= key_nxt;
    wval_r     <= wval_nxt;
    hit_r      <= hit_nxt;
    ev_r       <= ev_nxt;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    r_cnt_nxt    = r_cnt_r;
    mv_cnt_nxt   = mv_cnt_r;
    occ_nxt      = occ_r;
    slot_nxt     = slot_r;
    is_put_nxt   = is_put_r;
    key_nxt      = key_r;
    wval_nxt     = wval_r;
    grow_nxt     = grow_r;
    hit_nxt      = hit_r;
    ev_nxt       = ev_r;
    rd_nxt       = rd_r;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    rank_rd_addr = r_cnt_r[IW-1:0];
    rank_we      = 1'b0;
    rank_wa      = mv_cnt_r[IW-1:0];
    rank_wd      = rank_eff;
    key_we       = 1'b0;
    val_we       = 1'b0;
    kv_wa        = slot_r;
    load_out     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          is_put_nxt = in_tuser;
          key_nxt    = in_tdata[KEY_W-1:0];
          wval_nxt   = in_tdata[IN_DATA_W-1:KEY_W];
          r_cnt_nxt  = '0;
          hit_nxt    = 1'b0;
          ev_nxt     = 1'b0;
          rd_nxt     = '0;
          grow_nxt   = 1'b0;
          state_nxt  = (occ_r == '0) ? ST_MISS : ST_RANK;
        end
      end
      ST_RANK: begin
        rank_rd_addr = r_cnt_r[IW-1:0];
        state_nxt    = ST_KEY;
      end
      ST_KEY: begin
        slot_nxt  = rank_eff;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (key_q == key_r) begin
          hit_nxt    = 1'b1;
          mv_cnt_nxt = r_cnt_r;
          state_nxt  = ST_HITV;
        end else if (CW'(r_cnt_r + 1'b1) == occ_r) begin
          state_nxt = ST_MISS;
        end else begin
          r_cnt_nxt = CW'(r_cnt_r + 1'b1);
          state_nxt = ST_RANK;
        end
      end
      ST_HITV: begin
        if (is_put_r == REQ_PUT) begin
          val_we = 1'b1;
          kv_wa  = slot_r;
        end else begin
          rd_nxt = val_q;
        end
        state_nxt = ST_MV_RD;
      end
      ST_MISS: begin
        if (is_put_r == REQ_GET) begin
          state_nxt = ST_DONE;
        end else begin
          if (LW'(occ_r) >= lim) begin
            mv_cnt_nxt = CW'(occ_r - 1'b1);
            ev_nxt     = 1'b1;
            grow_nxt   = 1'b0;
          end else begin
            mv_cnt_nxt = occ_r;
            grow_nxt   = 1'b1;
          end
          state_nxt = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        rank_rd_addr = mv_cnt_r[IW-1:0];
        state_nxt    = ST_INS_SLOT;
      end
      ST_INS_SLOT: begin
        slot_nxt  = rank_eff;
        key_we    = 1'b1;
        val_we    = 1'b1;
        kv_wa     = rank_eff;
        state_nxt = ST_MV_RD;
      end
      ST_MV_RD: begin
        if (mv_cnt_r == '0) begin
          rank_we   = 1'b1;
          rank_wa   = '0;
          rank_wd   = slot_r;
          occ_nxt   = CW'(occ_r + CW'(grow_r));
          grow_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          rank_rd_addr = mv_cnt_r[IW-1:0] - 1'b1;
          state_nxt    = ST_MV_WR;
        end
      end
      ST_MV_WR: begin
        rank_we    = 1'b1;
        rank_wa    = mv_cnt_r[IW-1:0];
        rank_wd    = rank_eff;
        mv_cnt_nxt = CW'(mv_cnt_r - 1'b1);
        state_nxt  = ST_MV_RD;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out     = 1'b1;
          out_data_nxt = rd_r;
          out_user_nxt = {ev_r, hit_r};
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
